FILE: rtl/srvm_pkg.sv
// Shared types, sizes, opcode codes and the instruction decoder of the VM execute unit.
// Depends on nothing; srvm_itu and the top use scoped names, the benches import it.
package srvm_pkg;

    localparam int NUM_REGS    = 16;
    localparam int STACK_DEPTH = 256;
    localparam int RAM_WORDS   = 4096;

    localparam int RBITS  = $clog2(NUM_REGS);
    localparam int SABITS = $clog2(STACK_DEPTH);
    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int RABITS = $clog2(RAM_WORDS);

    localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

    localparam int FB_EQ   = 0;
    localparam int FB_NE   = 1;
    localparam int FB_GT   = 2;
    localparam int FB_LT   = 3;
    localparam int FB_OV   = 4;
    localparam int FB_STOP = 5;

    localparam logic [5:0] C_EXIT        = 6'd0;
    localparam logic [5:0] C_PUSH_LIT    = 6'd1;
    localparam logic [5:0] C_MOV_LIT_REG = 6'd2;
    localparam logic [5:0] C_PUSH_REG    = 6'd3;
    localparam logic [5:0] C_DUPE        = 6'd4;
    localparam logic [5:0] C_POP_REG     = 6'd5;
    localparam logic [5:0] C_RR_FIRST    = 6'd6;
    localparam logic [5:0] C_RR_NOT      = 6'd10;
    localparam logic [5:0] C_RR_LAST     = 6'd13;
    localparam logic [5:0] C_ST_FIRST    = 6'd14;
    localparam logic [5:0] C_ST_NOT      = 6'd18;
    localparam logic [5:0] C_ST_LAST     = 6'd21;
    localparam logic [5:0] C_INC_REG     = 6'd22;
    localparam logic [5:0] C_DEC_REG     = 6'd23;
    localparam logic [5:0] C_INC_STK     = 6'd24;
    localparam logic [5:0] C_DEC_STK     = 6'd25;
    localparam logic [5:0] C_LIT_FIRST   = 6'd26;
    localparam logic [5:0] C_LIT_LAST    = 6'd39;
    localparam logic [5:0] C_SQRT_REG    = 6'd40;
    localparam logic [5:0] C_SQRT_STK    = 6'd41;
    localparam logic [5:0] C_CMP_RR      = 6'd42;
    localparam logic [5:0] C_CMP_RL      = 6'd43;
    localparam logic [5:0] C_CMP_SL      = 6'd44;
    localparam logic [5:0] C_FLAG_RST    = 6'd45;
    localparam logic [5:0] C_POP_MEM     = 6'd46;
    localparam logic [5:0] C_MOV_LIT_MEM = 6'd47;
    localparam logic [5:0] C_MOV_MEM_REG = 6'd48;
    localparam logic [5:0] C_MOV_REG_MEM = 6'd49;
    localparam logic [5:0] C_MOV_REG_REG = 6'd50;
    localparam logic [5:0] C_MOV_MEM_MEM = 6'd51;
    localparam logic [5:0] C_PUSH_MEM    = 6'd52;
    localparam logic [5:0] C_JMP         = 6'd53;
    localparam logic [5:0] C_JE          = 6'd54;
    localparam logic [5:0] C_JO          = 6'd58;
    localparam logic [5:0] C_CALL        = 6'd59;
    localparam logic [5:0] C_RET         = 6'd60;

    typedef logic [2:0] t_src;
    localparam t_src SRC_NONE = 3'd0;
    localparam t_src SRC_LIT  = 3'd1;
    localparam t_src SRC_LIT2 = 3'd2;
    localparam t_src SRC_REGD = 3'd3;
    localparam t_src SRC_REGS = 3'd4;
    localparam t_src SRC_POP  = 3'd5;
    localparam t_src SRC_PEEK = 3'd6;
    localparam t_src SRC_RAM  = 3'd7;

    typedef logic [3:0] t_aop;
    localparam t_aop A_ADD  = 4'd0;
    localparam t_aop A_SUB  = 4'd1;
    localparam t_aop A_MUL  = 4'd2;
    localparam t_aop A_DIV  = 4'd3;
    localparam t_aop A_AND  = 4'd4;
    localparam t_aop A_OR   = 4'd5;
    localparam t_aop A_XOR  = 4'd6;
    localparam t_aop A_NOT  = 4'd7;
    localparam t_aop A_INC  = 4'd8;
    localparam t_aop A_DEC  = 4'd9;
    localparam t_aop A_SQRT = 4'd10;
    localparam t_aop A_CMP  = 4'd11;
    localparam t_aop A_PASS = 4'd12;

    typedef logic [2:0] t_dst;
    localparam t_dst D_NONE = 3'd0;
    localparam t_dst D_REG  = 3'd1;
    localparam t_dst D_PUSH = 3'd2;
    localparam t_dst D_RAM  = 3'd3;
    localparam t_dst D_RAM2 = 3'd4;

    typedef logic [2:0] t_cls;
    localparam t_cls K_NOP  = 3'd0;
    localparam t_cls K_ALU  = 3'd1;
    localparam t_cls K_EXIT = 3'd2;
    localparam t_cls K_FRST = 3'd3;
    localparam t_cls K_JUMP = 3'd4;
    localparam t_cls K_CALL = 3'd5;
    localparam t_cls K_RET  = 3'd6;

    typedef struct packed {
        t_cls       cls;
        t_src       asrc;
        t_src       bsrc;
        t_aop       aop;
        t_dst       dst;
        logic [3:0] len;
        logic       jall;
        logic [2:0] jbit;
    } t_dec;

    typedef struct packed {
        logic start;
        logic sqrt;
    } t_itu_req;

    function automatic t_aop rr_aop(input logic [2:0] k);
        t_aop o;
        unique case (k)
            3'd0:    o = A_ADD;
            3'd1:    o = A_SUB;
            3'd2:    o = A_MUL;
            3'd3:    o = A_DIV;
            3'd4:    o = A_NOT;
            3'd5:    o = A_AND;
            3'd6:    o = A_OR;
            default: o = A_XOR;
        endcase
        return o;
    endfunction

    function automatic t_aop lit_aop(input logic [2:0] k);
        t_aop o;
        unique case (k)
            3'd0:    o = A_ADD;
            3'd1:    o = A_SUB;
            3'd2:    o = A_MUL;
            3'd3:    o = A_DIV;
            3'd4:    o = A_AND;
            3'd5:    o = A_OR;
            default: o = A_XOR;
        endcase
        return o;
    endfunction

    function automatic t_dec decode(input logic [5:0] c);
        t_dec       d;
        logic [5:0] k;
        d.cls  = K_NOP;
        d.asrc = SRC_NONE;
        d.bsrc = SRC_NONE;
        d.aop  = A_PASS;
        d.dst  = D_NONE;
        d.len  = 4'd1;
        d.jall = 1'b0;
        d.jbit = 3'd0;
        k      = 6'd0;
        if (c >= C_RR_FIRST && c <= C_RR_LAST) begin
            k      = c - C_RR_FIRST;
            d.cls  = K_ALU;
            d.asrc = SRC_REGD;
            d.dst  = D_REG;
            d.aop  = rr_aop(k[2:0]);
            if (c == C_RR_NOT) begin
                d.len = 4'd2;
            end else begin
                d.bsrc = SRC_REGS;
                d.len  = 4'd3;
            end
        end else if (c >= C_ST_FIRST && c <= C_ST_LAST) begin
            k      = c - C_ST_FIRST;
            d.cls  = K_ALU;
            d.asrc = SRC_POP;
            d.dst  = D_PUSH;
            d.aop  = rr_aop(k[2:0]);
            if (c != C_ST_NOT) begin
                d.bsrc = SRC_POP;
            end
        end else if (c >= C_LIT_FIRST && c <= C_LIT_LAST) begin
            k     = c - C_LIT_FIRST;
            d.cls = K_ALU;
            d.aop = lit_aop(k[3:1]);
            if (!c[0]) begin
                d.asrc = SRC_REGD;
                d.bsrc = SRC_LIT;
                d.dst  = D_REG;
                d.len  = 4'd6;
            end else begin
                d.asrc = SRC_LIT;
                d.bsrc = SRC_POP;
                d.dst  = D_PUSH;
                d.len  = 4'd5;
            end
        end else if (c >= C_JMP && c <= C_JO) begin
            d.cls = K_JUMP;
            d.len = 4'd5;
            if (c == C_JMP) begin
                d.jall = 1'b1;
            end else begin
                k      = c - C_JE;
                d.jbit = k[2:0];
            end
        end else begin
            unique case (c)
                C_EXIT: d.cls = K_EXIT;
                C_PUSH_LIT: begin
                    d.cls = K_ALU; d.asrc = SRC_LIT; d.dst = D_PUSH; d.len = 4'd5;
                end
                C_MOV_LIT_REG: begin
                    d.cls = K_ALU; d.asrc = SRC_LIT; d.dst = D_REG; d.len = 4'd6;
                end
                C_PUSH_REG: begin
                    d.cls = K_ALU; d.asrc = SRC_REGD; d.dst = D_PUSH; d.len = 4'd2;
                end
                C_DUPE: begin
                    d.cls = K_ALU; d.asrc = SRC_PEEK; d.dst = D_PUSH;
                end
                C_POP_REG: begin
                    d.cls = K_ALU; d.asrc = SRC_POP; d.dst = D_REG; d.len = 4'd2;
                end
                C_INC_REG: begin
                    d.cls = K_ALU; d.asrc = SRC_REGD; d.aop = A_INC; d.dst = D_REG;
                    d.len = 4'd2;
                end
                C_DEC_REG: begin
                    d.cls = K_ALU; d.asrc = SRC_REGD; d.aop = A_DEC; d.dst = D_REG;
                    d.len = 4'd2;
                end
                C_INC_STK: begin
                    d.cls = K_ALU; d.asrc = SRC_POP; d.aop = A_INC; d.dst = D_PUSH;
                end
                C_DEC_STK: begin
                    d.cls = K_ALU; d.asrc = SRC_POP; d.aop = A_DEC; d.dst = D_PUSH;
                end
                C_SQRT_REG: begin
                    d.cls = K_ALU; d.asrc = SRC_REGD; d.aop = A_SQRT; d.dst = D_REG;
                    d.len = 4'd2;
                end
                C_SQRT_STK: begin
                    d.cls = K_ALU; d.asrc = SRC_POP; d.aop = A_SQRT; d.dst = D_PUSH;
                end
                C_CMP_RR: begin
                    d.cls = K_ALU; d.asrc = SRC_REGD; d.bsrc = SRC_REGS; d.aop = A_CMP;
                    d.len = 4'd3;
                end
                C_CMP_RL: begin
                    d.cls = K_ALU; d.asrc = SRC_REGD; d.bsrc = SRC_LIT; d.aop = A_CMP;
                    d.len = 4'd6;
                end
                C_CMP_SL: begin
                    d.cls = K_ALU; d.asrc = SRC_PEEK; d.bsrc = SRC_LIT; d.aop = A_CMP;
                    d.len = 4'd5;
                end
                C_FLAG_RST: d.cls = K_FRST;
                C_POP_MEM: begin
                    d.cls = K_ALU; d.asrc = SRC_POP; d.dst = D_RAM; d.len = 4'd5;
                end
                C_MOV_LIT_MEM: begin
                    d.cls = K_ALU; d.asrc = SRC_LIT2; d.dst = D_RAM; d.len = 4'd9;
                end
                C_MOV_MEM_REG: begin
                    d.cls = K_ALU; d.asrc = SRC_RAM; d.dst = D_REG; d.len = 4'd6;
                end
                C_MOV_REG_MEM: begin
                    d.cls = K_ALU; d.asrc = SRC_REGD; d.dst = D_RAM; d.len = 4'd6;
                end
                C_MOV_REG_REG: begin
                    d.cls = K_ALU; d.asrc = SRC_REGS; d.dst = D_REG; d.len = 4'd3;
                end
                C_MOV_MEM_MEM: begin
                    d.cls = K_ALU; d.asrc = SRC_RAM; d.dst = D_RAM2; d.len = 4'd9;
                end
                C_PUSH_MEM: begin
                    d.cls = K_ALU; d.asrc = SRC_RAM; d.dst = D_PUSH; d.len = 4'd5;
                end
                C_CALL: d.cls = K_CALL;
                C_RET:  d.cls = K_RET;
                default: d.cls = K_NOP;
            endcase
        end
        return d;
    endfunction

endpackage

FILE: rtl/srvm_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
module srvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/srvm_itu.sv
// Iterative unit: 32-bit restoring divide (one quotient bit a cycle) and floor square root
// (one result bit a cycle). Depends on srvm_pkg.
module srvm_itu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srvm_pkg::t_itu_req i_req,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output logic              o_done,
    output logic [31:0]       o_result
);

    logic        r_busy;
    logic        r_done;
    logic        r_sqrt;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [31:0] r_n;
    logic [31:0] r_r;
    logic [31:0] r_bit;

    logic [32:0] rem_sh;
    logic        q_bit;
    logic [32:0] rt_sum;
    logic        rt_take;

    assign rem_sh  = {r_rem, r_q[31]};
    assign q_bit   = rem_sh >= {1'b0, r_div};
    assign rt_sum  = {1'b0, r_r} + {1'b0, r_bit};
    assign rt_take = {1'b0, r_n} >= rt_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.sqrt;
                r_cnt  <= i_req.sqrt ? 5'd15 : 5'd31;
                r_q    <= i_a;
                r_rem  <= 32'd0;
                r_div  <= i_b;
                r_n    <= i_a;
                r_r    <= 32'd0;
                r_bit  <= 32'h4000_0000;
            end else if (r_busy) begin
                if (r_sqrt) begin
                    if (rt_take) begin
                        r_n <= r_n - rt_sum[31:0];
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_rem <= q_bit ? 32'(rem_sh - {1'b0, r_div}) : rem_sh[31:0];
                    r_q   <= {r_q[30:0], q_bit};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_sqrt ? r_r : r_q;

endmodule

FILE: rtl/stack_register_vm_execute_unit.sv
// Top level of the VM execute unit: sequencer over register file, stack and data RAM.
// Depends on srvm_pkg, srvm_ram and srvm_itu.
//
//  channel  | direction | handshake            | payload
//  request  | in        | i_in_valid/o_in_stall | command, dest_reg, src_reg, literal,
//           |           |                      | literal_two, instr_addr
//  result   | out       | o_out_valid/i_out_stall | next_pc, flags_out, stop, stack_fault
//
// One request at a time. Divide and square root run in srvm_itu (one quotient bit a
// cycle); call pushes registers 0 to 3, then the pc; return cuts the stack to the frame
// base, pops the return address, then registers 3 to 0. Memory reads land in S_WAIT.
// After reset the data RAM is swept to zero with o_in_stall high.
// A new request is taken while the previous result waits in the output register.
module stack_register_vm_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [5:0]  i_command,
    input  logic [3:0]  i_dest_reg,
    input  logic [3:0]  i_src_reg,
    input  logic [31:0] i_literal,
    input  logic [31:0] i_literal_two,
    input  logic [31:0] i_instr_addr,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_next_pc,
    output logic [4:0]  o_flags_out,
    output logic        o_stop,
    output logic        o_stack_fault
);

    localparam int RB  = srvm_pkg::RBITS;
    localparam int SA  = srvm_pkg::SABITS;
    localparam int SPW = srvm_pkg::SPW;
    localparam int RA  = srvm_pkg::RABITS;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_FETCH     = 4'd2;
    localparam logic [3:0] S_WAIT      = 4'd3;
    localparam logic [3:0] S_EXEC      = 4'd4;
    localparam logic [3:0] S_ITER      = 4'd5;
    localparam logic [3:0] S_STORE     = 4'd6;
    localparam logic [3:0] S_CALL_RD   = 4'd7;
    localparam logic [3:0] S_CALL_PUSH = 4'd8;
    localparam logic [3:0] S_RET_CUT   = 4'd9;
    localparam logic [3:0] S_RET_POP   = 4'd10;
    localparam logic [3:0] S_RET_USE   = 4'd11;
    localparam logic [3:0] S_FINISH    = 4'd12;

    localparam logic [1:0] M_REG = 2'd0;
    localparam logic [1:0] M_STK = 2'd1;
    localparam logic [1:0] M_RAM = 2'd2;

    logic [3:0]          r_state, n_state;
    srvm_pkg::t_dec      r_dec, n_dec;
    logic [RB-1:0]       r_d, n_d;
    logic [RB-1:0]       r_s, n_s;
    logic [31:0]         r_lit, n_lit;
    logic [31:0]         r_lit2, n_lit2;
    logic [31:0]         r_pc, n_pc;
    logic [31:0]         r_a, n_a;
    logic [31:0]         r_b, n_b;
    logic [31:0]         r_res, n_res;
    logic                r_phase, n_phase;
    logic [1:0]          r_wsel, n_wsel;
    logic                r_zero, n_zero;
    logic                r_rv;
    logic [SPW-1:0]      r_sp, n_sp;
    logic [SPW-1:0]      r_fb, n_fb;
    logic [5:0]          r_flags, n_flags;
    logic                r_fault, n_fault;
    logic                r_jump, n_jump;
    logic [31:0]         r_target, n_target;
    logic [2:0]          r_cnt, n_cnt;
    logic [RA-1:0]       r_clr, n_clr;
    logic [srvm_pkg::NUM_REGS-1:0] r_rvld;
    logic                r_ovalid, n_ovalid;
    logic [31:0]         r_onpc, n_onpc;
    logic [4:0]          r_oflags, n_oflags;
    logic                r_ostop, n_ostop;
    logic                r_ofault, n_ofault;

    logic                reg_we;
    logic [RB-1:0]       reg_waddr, reg_raddr;
    logic [31:0]         reg_wdata, reg_rdata, reg_val;
    logic                stk_we;
    logic [SA-1:0]       stk_waddr, stk_raddr;
    logic [31:0]         stk_wdata, stk_rdata, stk_val;
    logic                ram_we;
    logic [RA-1:0]       ram_waddr, ram_raddr;
    logic [31:0]         ram_wdata, ram_rdata;

    srvm_pkg::t_itu_req  itu_req;
    logic                itu_done;
    logic [31:0]         itu_res;

    logic                do_push, do_pop, pop_keep, take_fb;
    logic [31:0]         push_val;
    logic                fdone;
    logic [31:0]         fval;
    srvm_pkg::t_src      fsrc;
    logic [32:0]         sum33;
    logic [63:0]         prod;
    logic [2:0]          ret_idx;

    srvm_ram #(.WIDTH(32), .DEPTH(srvm_pkg::NUM_REGS)) u_regs (
        .i_clk(i_clk), .i_we(reg_we), .i_waddr(reg_waddr), .i_wdata(reg_wdata),
        .i_raddr(reg_raddr), .o_rdata(reg_rdata)
    );

    srvm_ram #(.WIDTH(32), .DEPTH(srvm_pkg::STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    srvm_ram #(.WIDTH(32), .DEPTH(srvm_pkg::RAM_WORDS)) u_data (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    srvm_itu u_itu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(itu_req), .i_a(r_a), .i_b(r_b),
        .o_done(itu_done), .o_result(itu_res)
    );

    assign reg_val = r_rv ? reg_rdata : 32'd0;
    assign stk_val = r_zero ? 32'd0 : stk_rdata;
    assign fsrc    = r_phase ? r_dec.bsrc : r_dec.asrc;
    assign ret_idx = 3'd4 - r_cnt;

    always_comb begin
        n_state  = r_state;
        n_dec    = r_dec;
        n_d      = r_d;
        n_s      = r_s;
        n_lit    = r_lit;
        n_lit2   = r_lit2;
        n_pc     = r_pc;
        n_a      = r_a;
        n_b      = r_b;
        n_res    = r_res;
        n_phase  = r_phase;
        n_wsel   = r_wsel;
        n_zero   = r_zero;
        n_sp     = r_sp;
        n_fb     = r_fb;
        n_flags  = r_flags;
        n_fault  = r_fault;
        n_jump   = r_jump;
        n_target = r_target;
        n_cnt    = r_cnt;
        n_clr    = r_clr;
        n_ovalid = r_ovalid && i_out_stall;
        n_onpc   = r_onpc;
        n_oflags = r_oflags;
        n_ostop  = r_ostop;
        n_ofault = r_ofault;
        reg_we    = 1'b0;
        reg_waddr = r_d;
        reg_wdata = r_res;
        reg_raddr = r_d;
        stk_raddr = SA'(r_sp - SPW'(1));
        ram_we    = 1'b0;
        ram_waddr = r_lit[RA-1:0];
        ram_wdata = r_res;
        ram_raddr = r_lit[RA-1:0];
        itu_req   = '0;
        do_push   = 1'b0;
        push_val  = r_res;
        do_pop    = 1'b0;
        pop_keep  = 1'b0;
        take_fb   = 1'b0;
        fdone     = 1'b0;
        fval      = 32'd0;
        sum33     = 33'd0;
        prod      = 64'd0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 32'd0;
                n_clr     = r_clr + RA'(1);
                if (r_clr == RA'(srvm_pkg::RAM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_dec   = srvm_pkg::decode(i_command);
                    n_d     = RB'(i_dest_reg);
                    n_s     = RB'(i_src_reg);
                    n_lit   = i_literal;
                    n_lit2  = i_literal_two;
                    n_pc    = i_instr_addr;
                    n_phase = 1'b0;
                    n_fault = 1'b0;
                    n_jump  = 1'b0;
                    n_a     = 32'd0;
                    n_b     = 32'd0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                case (fsrc)
                    srvm_pkg::SRC_LIT: begin
                        fval = r_lit; fdone = 1'b1;
                    end
                    srvm_pkg::SRC_LIT2: begin
                        fval = r_lit2; fdone = 1'b1;
                    end
                    srvm_pkg::SRC_REGD: begin
                        reg_raddr = r_d; n_wsel = M_REG; n_state = S_WAIT;
                    end
                    srvm_pkg::SRC_REGS: begin
                        reg_raddr = r_s; n_wsel = M_REG; n_state = S_WAIT;
                    end
                    srvm_pkg::SRC_POP: begin
                        do_pop = 1'b1; n_wsel = M_STK; n_state = S_WAIT;
                    end
                    srvm_pkg::SRC_PEEK: begin
                        do_pop = 1'b1; pop_keep = 1'b1; n_wsel = M_STK; n_state = S_WAIT;
                    end
                    srvm_pkg::SRC_RAM: begin
                        n_wsel = M_RAM; n_state = S_WAIT;
                    end
                    default: fdone = 1'b1;
                endcase
            end
            S_WAIT: begin
                fdone = 1'b1;
                case (r_wsel)
                    M_REG:   fval = reg_val;
                    M_STK:   fval = stk_val;
                    default: fval = ram_rdata;
                endcase
            end
            S_EXEC: begin
                n_state = S_FINISH;
                unique case (r_dec.cls)
                    srvm_pkg::K_ALU: begin
                        n_state = S_STORE;
                        case (r_dec.aop)
                            srvm_pkg::A_ADD: begin
                                sum33 = {1'b0, r_a} + {1'b0, r_b};
                                n_res = sum33[31:0];
                                if (sum33[32]) n_flags[srvm_pkg::FB_OV] = 1'b1;
                            end
                            srvm_pkg::A_SUB: begin
                                n_res = r_a - r_b;
                                if (r_a < r_b) n_flags[srvm_pkg::FB_OV] = 1'b1;
                            end
                            srvm_pkg::A_MUL: begin
                                prod  = 64'(r_a) * 64'(r_b);
                                n_res = prod[31:0];
                                if (|prod[63:32]) n_flags[srvm_pkg::FB_OV] = 1'b1;
                            end
                            srvm_pkg::A_DIV: begin
                                itu_req.start = 1'b1; n_state = S_ITER;
                            end
                            srvm_pkg::A_SQRT: begin
                                itu_req.start = 1'b1; itu_req.sqrt = 1'b1; n_state = S_ITER;
                            end
                            srvm_pkg::A_AND: n_res = r_a & r_b;
                            srvm_pkg::A_OR:  n_res = r_a | r_b;
                            srvm_pkg::A_XOR: n_res = r_a ^ r_b;
                            srvm_pkg::A_NOT: n_res = ~r_a;
                            srvm_pkg::A_INC: begin
                                n_res = r_a + 32'd1;
                                if (r_a == srvm_pkg::WORD_MAX) n_flags[srvm_pkg::FB_OV] = 1'b1;
                            end
                            srvm_pkg::A_DEC: begin
                                n_res = r_a - 32'd1;
                                if (r_a == 32'd0) n_flags[srvm_pkg::FB_OV] = 1'b1;
                            end
                            srvm_pkg::A_CMP: begin
                                n_flags[srvm_pkg::FB_EQ] = r_a == r_b;
                                n_flags[srvm_pkg::FB_NE] = r_a != r_b;
                                n_flags[srvm_pkg::FB_GT] = r_a > r_b;
                                n_flags[srvm_pkg::FB_LT] = r_a < r_b;
                            end
                            default: n_res = r_a;
                        endcase
                    end
                    srvm_pkg::K_EXIT: n_flags[srvm_pkg::FB_STOP] = 1'b1;
                    srvm_pkg::K_FRST: n_flags[srvm_pkg::FB_STOP - 1:0] = '0;
                    srvm_pkg::K_JUMP: begin
                        if (r_dec.jall || r_flags[r_dec.jbit]) begin
                            n_jump   = 1'b1;
                            n_target = r_lit;
                        end
                    end
                    srvm_pkg::K_CALL: begin
                        n_cnt = 3'd0; n_state = S_CALL_RD;
                    end
                    srvm_pkg::K_RET: n_state = S_RET_CUT;
                    default: n_state = S_FINISH;
                endcase
            end
            S_ITER: begin
                if (itu_done) begin
                    n_res   = itu_res;
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_state = S_FINISH;
                case (r_dec.dst)
                    srvm_pkg::D_REG:  reg_we = 1'b1;
                    srvm_pkg::D_PUSH: do_push = 1'b1;
                    srvm_pkg::D_RAM:  ram_we = 1'b1;
                    srvm_pkg::D_RAM2: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_lit2[RA-1:0];
                    end
                    default: ;
                endcase
            end
            S_CALL_RD: begin
                reg_raddr = RB'(r_cnt[1:0]);
                n_state   = S_CALL_PUSH;
            end
            S_CALL_PUSH: begin
                do_push  = 1'b1;
                push_val = r_cnt[2] ? r_pc : reg_val;
                if (r_cnt[2]) begin
                    take_fb  = 1'b1;
                    n_jump   = 1'b1;
                    n_target = r_lit;
                    n_state  = S_FINISH;
                end else begin
                    n_cnt   = r_cnt + 3'd1;
                    n_state = (r_cnt == 3'd3) ? S_CALL_PUSH : S_CALL_RD;
                end
            end
            S_RET_CUT: begin
                if (r_fb < r_sp) n_sp = r_fb;
                n_cnt   = 3'd0;
                n_state = S_RET_POP;
            end
            S_RET_POP: begin
                do_pop  = 1'b1;
                n_state = S_RET_USE;
            end
            S_RET_USE: begin
                if (r_cnt == 3'd0) begin
                    n_jump   = 1'b1;
                    n_target = stk_val + 32'd5;
                end else begin
                    reg_we    = 1'b1;
                    reg_waddr = RB'(ret_idx[1:0]);
                    reg_wdata = stk_val;
                end
                if (r_cnt == 3'd4) begin
                    n_fb    = r_sp;
                    n_state = S_FINISH;
                end else begin
                    n_cnt   = r_cnt + 3'd1;
                    n_state = S_RET_POP;
                end
            end
            S_FINISH: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_onpc   = r_jump ? r_target : r_pc + 32'(r_dec.len);
                    n_oflags = r_flags[4:0];
                    n_ostop  = r_flags[srvm_pkg::FB_STOP];
                    n_ofault = r_fault;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (fdone) begin
            if (!r_phase) begin
                n_a     = fval;
                n_phase = 1'b1;
                n_state = S_FETCH;
            end else begin
                n_b     = fval;
                n_state = S_EXEC;
            end
        end

        if (do_pop) begin
            if (r_sp == SPW'(0)) begin
                n_fault = 1'b1;
                n_zero  = 1'b1;
            end else begin
                n_zero = 1'b0;
                if (!pop_keep) n_sp = r_sp - SPW'(1);
            end
        end

        stk_we    = 1'b0;
        stk_waddr = r_sp[SA-1:0];
        stk_wdata = push_val;
        if (do_push) begin
            if (r_sp >= SPW'(srvm_pkg::STACK_DEPTH)) begin
                n_fault = 1'b1;
            end else begin
                stk_we = 1'b1;
                n_sp   = r_sp + SPW'(1);
            end
        end
        if (take_fb) n_fb = n_sp;
    end

    assign o_in_stall    = r_state != S_IDLE;
    assign o_out_valid   = r_ovalid;
    assign o_next_pc     = r_onpc;
    assign o_flags_out   = r_oflags;
    assign o_stop        = r_ostop;
    assign o_stack_fault = r_ofault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_sp     <= '0;
            r_fb     <= '0;
            r_flags  <= '0;
            r_rvld   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_sp     <= n_sp;
            r_fb     <= n_fb;
            r_flags  <= n_flags;
            r_ovalid <= n_ovalid;
            if (reg_we) r_rvld[reg_waddr] <= 1'b1;
        end
        r_dec    <= n_dec;
        r_d      <= n_d;
        r_s      <= n_s;
        r_lit    <= n_lit;
        r_lit2   <= n_lit2;
        r_pc     <= n_pc;
        r_a      <= n_a;
        r_b      <= n_b;
        r_res    <= n_res;
        r_phase  <= n_phase;
        r_wsel   <= n_wsel;
        r_zero   <= n_zero;
        r_rv     <= r_rvld[reg_raddr];
        r_fault  <= n_fault;
        r_jump   <= n_jump;
        r_target <= n_target;
        r_cnt    <= n_cnt;
        r_onpc   <= n_onpc;
        r_oflags <= n_oflags;
        r_ostop  <= n_ostop;
        r_ofault <= n_ofault;
    end

endmodule

FILE: tb/stack_register_vm_execute_unit_chk.sv
`timescale 1ns / 1ps
// Checker for the VM execute unit: watches the request and result channels, predicts
// each result from its own copy of registers, stack, RAM and flags, and counts mismatches.
// Depends on srvm_pkg for sizes and command codes.
module stack_register_vm_execute_unit_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [5:0]  i_command,
    input  logic [3:0]  i_dest_reg,
    input  logic [3:0]  i_src_reg,
    input  logic [31:0] i_literal,
    input  logic [31:0] i_literal_two,
    input  logic [31:0] i_instr_addr,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_next_pc,
    input  logic [4:0]  i_flags_out,
    input  logic        i_stop,
    input  logic        i_stack_fault,
    output int          o_errors,
    output int          o_pending
);
    import srvm_pkg::*;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR
    } t_math;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [4:0]  flags;
        logic        stop;
        logic        fault;
    } t_result;

    t_result     pending_results[$];
    logic [31:0] regs[NUM_REGS];
    logic [31:0] stack_words[STACK_DEPTH];
    logic [31:0] ram_words[RAM_WORDS];
    logic [8:0]  depth;
    logic [8:0]  frame_ptr;
    logic [5:0]  flag_reg;
    logic        fault;
    int          errors;

    assign o_errors  = errors;
    assign o_pending = pending_results.size();

    task automatic stk_push(input logic [31:0] v);
        if (depth >= STACK_DEPTH) begin
            fault = 1'b1;
        end else begin
            stack_words[depth] = v;
            depth = depth + 9'd1;
        end
    endtask

    task automatic stk_pop(output logic [31:0] v);
        if (depth == 0) begin
            fault = 1'b1;
            v = '0;
        end else begin
            depth = depth - 9'd1;
            v = stack_words[depth];
        end
    endtask

    task automatic stk_top(output logic [31:0] v);
        if (depth == 0) begin
            fault = 1'b1;
            v = '0;
        end else begin
            v = stack_words[depth - 9'd1];
        end
    endtask

    task automatic set_compare(input logic [31:0] a, input logic [31:0] b);
        flag_reg[FB_EQ] = (a == b);
        flag_reg[FB_NE] = (a != b);
        flag_reg[FB_GT] = (a > b);
        flag_reg[FB_LT] = (a < b);
    endtask

    task automatic math(input t_math op, input logic [31:0] a, input logic [31:0] b,
                        output logic [31:0] r);
        logic [32:0] wide;
        logic [63:0] prod;
        case (op)
            OP_ADD: begin
                wide = {1'b0, a} + {1'b0, b};
                if (wide[32]) flag_reg[FB_OV] = 1'b1;
                r = wide[31:0];
            end
            OP_SUB: begin
                if (a < b) flag_reg[FB_OV] = 1'b1;
                r = a - b;
            end
            OP_MUL: begin
                prod = {32'd0, a} * {32'd0, b};
                if (prod[63:32] != 0) flag_reg[FB_OV] = 1'b1;
                r = prod[31:0];
            end
            OP_DIV:  r = (b == 0) ? WORD_MAX : a / b;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            default: r = a ^ b;
        endcase
    endtask

    function automatic logic [31:0] floor_root(input logic [31:0] v);
        logic [31:0] r;
        logic [31:0] cand;
        r = '0;
        for (int i = 15; i >= 0; i--) begin
            cand = r | (32'd1 << i);
            if ({32'd0, cand} * {32'd0, cand} <= {32'd0, v}) r = cand;
        end
        return r;
    endfunction

    function automatic t_math rr_math(input int k);
        case (k)
            0: return OP_ADD;
            1: return OP_SUB;
            2: return OP_MUL;
            3: return OP_DIV;
            5: return OP_AND;
            6: return OP_OR;
            default: return OP_XOR;
        endcase
    endfunction

    task automatic execute(input logic [5:0] c, input logic [3:0] d, input logic [3:0] s,
                           input logic [31:0] lit, input logic [31:0] lit2,
                           input logic [31:0] pc);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] len;
        logic [31:0] target;
        logic        jumped;
        t_result     res;
        len = 1;
        jumped = 1'b0;
        target = '0;
        fault = 1'b0;
        if (c >= C_RR_FIRST && c <= C_RR_LAST) begin
            if (c == C_RR_NOT) begin
                regs[d] = ~regs[d];
                len = 2;
            end else begin
                math(rr_math(c - C_RR_FIRST), regs[d], regs[s], r);
                regs[d] = r;
                len = 3;
            end
        end else if (c >= C_ST_FIRST && c <= C_ST_LAST) begin
            if (c == C_ST_NOT) begin
                stk_pop(a);
                stk_push(~a);
            end else begin
                stk_pop(a);
                stk_pop(b);
                math(rr_math(c - C_ST_FIRST), a, b, r);
                stk_push(r);
            end
        end else if (c >= C_LIT_FIRST && c <= C_LIT_LAST) begin
            if (!c[0]) begin
                math(t_math'((c - C_LIT_FIRST) >> 1), regs[d], lit, r);
                regs[d] = r;
                len = 6;
            end else begin
                stk_pop(b);
                math(t_math'((c - C_LIT_FIRST) >> 1), lit, b, r);
                stk_push(r);
                len = 5;
            end
        end else if (c >= C_JMP && c <= C_JO) begin
            len = 5;
            if (c == C_JMP || flag_reg[c - C_JE]) begin
                jumped = 1'b1;
                target = lit;
            end
        end else begin
            case (c)
                C_EXIT:        flag_reg[FB_STOP] = 1'b1;
                C_PUSH_LIT:    begin stk_push(lit); len = 5; end
                C_MOV_LIT_REG: begin regs[d] = lit; len = 6; end
                C_PUSH_REG:    begin stk_push(regs[d]); len = 2; end
                C_DUPE:        begin stk_top(a); stk_push(a); end
                C_POP_REG:     begin stk_pop(a); regs[d] = a; len = 2; end
                C_INC_REG: begin
                    if (regs[d] == WORD_MAX) flag_reg[FB_OV] = 1'b1;
                    regs[d] = regs[d] + 1;
                    len = 2;
                end
                C_DEC_REG: begin
                    if (regs[d] == 0) flag_reg[FB_OV] = 1'b1;
                    regs[d] = regs[d] - 1;
                    len = 2;
                end
                C_INC_STK: begin
                    stk_pop(a);
                    if (a == WORD_MAX) flag_reg[FB_OV] = 1'b1;
                    stk_push(a + 1);
                end
                C_DEC_STK: begin
                    stk_pop(a);
                    if (a == 0) flag_reg[FB_OV] = 1'b1;
                    stk_push(a - 1);
                end
                C_SQRT_REG:    begin regs[d] = floor_root(regs[d]); len = 2; end
                C_SQRT_STK:    begin stk_pop(a); stk_push(floor_root(a)); end
                C_CMP_RR:      begin set_compare(regs[d], regs[s]); len = 3; end
                C_CMP_RL:      begin set_compare(regs[d], lit); len = 6; end
                C_CMP_SL:      begin stk_top(a); set_compare(a, lit); len = 5; end
                C_FLAG_RST:    flag_reg[4:0] = '0;
                C_POP_MEM: begin
                    stk_pop(a);
                    ram_words[lit % RAM_WORDS] = a;
                    len = 5;
                end
                C_MOV_LIT_MEM: begin ram_words[lit % RAM_WORDS] = lit2; len = 9; end
                C_MOV_MEM_REG: begin regs[d] = ram_words[lit % RAM_WORDS]; len = 6; end
                C_MOV_REG_MEM: begin ram_words[lit % RAM_WORDS] = regs[d]; len = 6; end
                C_MOV_REG_REG: begin regs[d] = regs[s]; len = 3; end
                C_MOV_MEM_MEM: begin
                    ram_words[lit2 % RAM_WORDS] = ram_words[lit % RAM_WORDS];
                    len = 9;
                end
                C_PUSH_MEM:    begin stk_push(ram_words[lit % RAM_WORDS]); len = 5; end
                C_CALL: begin
                    for (int i = 0; i < 4; i++) stk_push(regs[i]);
                    stk_push(pc);
                    frame_ptr = depth;
                    jumped = 1'b1;
                    target = lit;
                end
                C_RET: begin
                    if (frame_ptr < depth) depth = frame_ptr;
                    stk_pop(a);
                    target = a + 5;
                    for (int i = 3; i >= 0; i--) begin
                        stk_pop(a);
                        regs[i] = a;
                    end
                    frame_ptr = depth;
                    jumped = 1'b1;
                end
                default: ;
            endcase
        end
        res.next_pc = jumped ? target : pc + len;
        res.flags   = flag_reg[4:0];
        res.stop    = flag_reg[FB_STOP];
        res.fault   = fault;
        pending_results.push_back(res);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial begin
        errors = 0;
        depth = '0;
        frame_ptr = '0;
        flag_reg = '0;
        fault = 1'b0;
        foreach (regs[i]) regs[i] = '0;
        foreach (stack_words[i]) stack_words[i] = '0;
        foreach (ram_words[i]) ram_words[i] = '0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            execute(i_command, i_dest_reg, i_src_reg, i_literal, i_literal_two,
                    i_instr_addr);
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", i_next_pc, '0);
            end else begin
                want = pending_results.pop_front();
                if (i_next_pc !== want.next_pc) report("next_pc", i_next_pc, want.next_pc);
                if (i_flags_out !== want.flags) report("flags", i_flags_out, want.flags);
                if (i_stop !== want.stop) report("stop", i_stop, want.stop);
                if (i_stack_fault !== want.fault) report("fault", i_stack_fault, want.fault);
            end
        end
    end

endmodule

FILE: tb/stack_register_vm_execute_unit_tb.sv
`timescale 1ns / 1ps
// Top of the VM execute unit testbench: clock, reset, request stimulus and result stalls.
// Depends on srvm_pkg, the execute unit and stack_register_vm_execute_unit_chk.
module stack_register_vm_execute_unit_tb;
    import srvm_pkg::*;

    localparam logic [5:0] C_UNUSED_LO = 6'd61;
    localparam logic [5:0] C_UNUSED_HI = 6'd63;
    localparam int         CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [5:0]  i_command;
    logic [3:0]  i_dest_reg;
    logic [3:0]  i_src_reg;
    logic [31:0] i_literal;
    logic [31:0] i_literal_two;
    logic [31:0] i_instr_addr;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_next_pc;
    logic [4:0]  o_flags_out;
    logic        o_stop;
    logic        o_stack_fault;
    int          errors;
    int          pending;
    int          cycles;
    int          sent;
    logic        gaps_on;
    logic        hold_go;

    stack_register_vm_execute_unit dut (.*);

    stack_register_vm_execute_unit_chk chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_command, .i_dest_reg,
        .i_src_reg, .i_literal, .i_literal_two, .i_instr_addr, .i_out_valid(o_out_valid),
        .i_out_stall, .i_next_pc(o_next_pc), .i_flags_out(o_flags_out), .i_stop(o_stop),
        .i_stack_fault(o_stack_fault), .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return WORD_MAX;
            2: return $urandom_range(0, 20);
            3: return WORD_MAX - $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        int n;
        if (hold_go) begin
            hold_go <= 1'b0;
            i_out_stall <= 1'b1;
            repeat (600) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            n = pick_gap();
            i_out_stall <= (n != 0);
            repeat (n) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_req(input logic [5:0] c, input logic [3:0] d, input logic [3:0] s,
                            input logic [31:0] lit, input logic [31:0] lit2);
        int n;
        i_in_valid    <= 1'b1;
        i_command     <= c;
        i_dest_reg    <= d;
        i_src_reg     <= s;
        i_literal     <= lit;
        i_literal_two <= lit2;
        i_instr_addr  <= pick_word();
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        n = gaps_on ? pick_gap() : 0;
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_any();
        send_req(6'($urandom_range(0, 63)), 4'($urandom), 4'($urandom), pick_word(),
                 pick_word());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        cycles = 0;
        sent = 0;
        gaps_on = 1'b0;
        hold_go = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_command = '0;
        i_dest_reg = '0;
        i_src_reg = '0;
        i_literal = '0;
        i_literal_two = '0;
        i_instr_addr = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-stack faults, carries, divide by zero, zero multiply, jumps, frames
        send_req(C_POP_REG, 4'd1, 4'd0, 32'd0, 32'd0);
        send_req(C_DUPE, 4'd0, 4'd0, 32'd0, 32'd0);
        send_req(C_CMP_SL, 4'd0, 4'd0, 32'd5, 32'd0);
        send_req(C_PUSH_LIT, 4'd0, 4'd0, WORD_MAX, 32'd0);
        send_req(C_PUSH_LIT, 4'd0, 4'd0, 32'd1, 32'd0);
        send_req(C_ST_FIRST, 4'd0, 4'd0, 32'd0, 32'd0);
        send_req(C_DEC_STK, 4'd0, 4'd0, 32'd0, 32'd0);
        send_req(C_MOV_LIT_REG, 4'd15, 4'd0, WORD_MAX, 32'd0);
        send_req(C_INC_REG, 4'd15, 4'd0, 32'd0, 32'd0);
        send_req(C_FLAG_RST, 4'd0, 4'd0, 32'd0, 32'd0);
        send_req(C_RR_FIRST + 6'd3, 4'd2, 4'd3, 32'd0, 32'd0);
        send_req(C_RR_FIRST + 6'd2, 4'd2, 4'd4, 32'd0, 32'd0);
        send_req(C_SQRT_REG, 4'd2, 4'd0, 32'd0, 32'd0);
        send_req(C_CMP_RL, 4'd2, 4'd0, WORD_MAX, 32'd0);
        send_req(C_JE, 4'd0, 4'd0, 32'h1234, 32'd0);
        send_req(C_JE + 6'd3, 4'd0, 4'd0, 32'h5678, 32'd0);
        send_req(C_MOV_LIT_MEM, 4'd0, 4'd0, WORD_MAX, 32'hA5A5_5A5A);
        send_req(C_MOV_MEM_MEM, 4'd0, 4'd0, 32'd4095, 32'd7);
        send_req(C_CALL, 4'd0, 4'd0, 32'h100, 32'd0);
        send_req(C_POP_REG, 4'd5, 4'd0, 32'd0, 32'd0);
        send_req(C_POP_REG, 4'd5, 4'd0, 32'd0, 32'd0);
        send_req(C_RET, 4'd0, 4'd0, 32'd0, 32'd0);
        send_req(C_UNUSED_LO, 4'd0, 4'd0, 32'd0, 32'd0);
        send_req(C_UNUSED_HI, 4'd0, 4'd0, 32'd0, 32'd0);
        drain();

        gaps_on = 1'b1;
        for (int i = 0; i < 264; i++) send_req(C_PUSH_LIT, 4'd0, 4'd0, $urandom, 32'd0);
        hold_go = 1'b1;
        for (int i = 0; i < 140; i++) send_any();
        for (int i = 0; i < 270; i++) send_req(C_POP_REG, 4'($urandom), 4'd0, 32'd0, 32'd0);
        drain();

        for (int blk = 0; blk < 60; blk++) begin
            gaps_on = (blk % 10) != 9;
            if ($urandom_range(0, 2) != 0) begin
                for (int i = 0; i < 3; i++) begin
                    send_req(C_PUSH_LIT, 4'd0, 4'd0, pick_word(), 32'd0);
                end
                send_req(C_CALL, 4'd0, 4'd0, $urandom, 32'd0);
                repeat ($urandom_range(0, 6)) send_any();
                send_req(C_RET, 4'd0, 4'd0, 32'd0, 32'd0);
            end else begin
                repeat ($urandom_range(4, 12)) send_any();
            end
            if (blk == 30) drain();
        end
        if (o_stop == 1'b0) send_req(C_EXIT, 4'd0, 4'd0, 32'd0, 32'd0);
        drain();
        repeat (100) @(posedge i_clk);

        $display("covered %0d requests: edge values, full and empty stack, call frames,", sent);
        $display("long result hold-off and random idling on both channels");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: stack_register_vm_execute_unit.f
rtl/srvm_pkg.sv
rtl/srvm_ram.sv
rtl/srvm_itu.sv
rtl/stack_register_vm_execute_unit.sv
tb/stack_register_vm_execute_unit_chk.sv
tb/stack_register_vm_execute_unit_tb.sv
